[sv/ccm_pkg.sv]
`default_nettype none
package ccm_pkg;

   localparam int COORD_W  = 15;
   localparam int OFFS_W   = 16;
   localparam int SQ_W     = 31;
   localparam int D2_W     = 32;
   localparam int RADIUS_W = 14;
   localparam int R2_W     = 28;
   localparam int RB2_W    = 29;
   localparam int DVS_W    = 15;
   localparam int ALPHA_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [RADIUS_W-1:0] RADIUS_RST = 14'd1;
   localparam logic [ALPHA_W-1:0]  ALPHA_FULL = 8'hFF;
   localparam logic [ALPHA_W-1:0]  ALPHA_NONE = 8'h00;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS   = 2'd0,
      CSR_CENTER_X = 2'd1,
      CSR_CENTER_Y = 2'd2,
      CSR_SMOOTH   = 2'd3
   } csr_index_type;

   // Where a pixel falls relative to the circle
   typedef enum logic [1:0] {
      CLS_OUTSIDE,
      CLS_INSIDE,
      CLS_RING
   } pix_class_type;

   typedef struct packed {
      logic [DVS_W-1:0] rem;
      logic             qbit;
   } div_step_type;

   // One restoring-division step; rem stays below the divisor
   function automatic div_step_type div_step(input logic [DVS_W-1:0] rem,
                                             input logic [DVS_W-1:0] dvs);
      logic [DVS_W:0] shifted;
      logic [DVS_W:0] diff;
      div_step_type   res;
      shifted = {rem, 1'b0};
      diff    = shifted - {1'b0, dvs};
      if (shifted >= {1'b0, dvs}) begin
         res.rem  = diff[DVS_W-1:0];
         res.qbit = 1'b1;
      end else begin
         res.rem  = shifted[DVS_W-1:0];
         res.qbit = 1'b0;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

[sv/ccm_ifs.sv]
`default_nettype none
interface ccm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ccm_pkg::COORD_W-1:0]   pixel_x;
   logic signed [ccm_pkg::COORD_W-1:0]   pixel_y;
   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface ccm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ccm_pkg::ALPHA_W-1:0]   alpha;
   modport source (output valid, output alpha, input ready);
   modport sink   (input valid, input alpha, output ready);
endinterface

interface ccm_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ccm_pkg::CSR_IDX_W-1:0]    index;
   logic [ccm_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[sv/circle_coverage_mask_pixel_core.sv]
// Circle coverage mask, one pixel per clock.
// req_bus carries one pixel coordinate (pixel_x, pixel_y) per beat; rsp_bus
// returns its 8-bit mask alpha, one beat per request, in request order.
// csr_bus writes the radius, center_x, center_y and smooth_edge registers;
// it is always ready and is meant to be used only while the pipeline is empty.
// Throughput: one pixel per cycle while rsp_bus does not stall, set by the
// eight-stage pipeline: offsets, squaring multipliers, distance sum, ring
// compare, then four stages of two restoring-division steps each, the last
// feeding the output register. Radius squares come from a pair of registered
// multipliers. Reset (synchronous, active high) empties the pipeline and
// loads radius 1, center (0,0) and smoothing off.
// When rsp_bus stalls, each stage holds its beat only if the stage after it
// is full and stalled, so bubbles are squeezed out and req_bus keeps taking
// beats until all eight stages are full; nothing is dropped or repeated.
`default_nettype none
module circle_coverage_mask_pixel_core (
   input wire logic   clock,
   input wire logic   reset,
   ccm_req_if.sink    req_bus,
   ccm_rsp_if.source  rsp_bus,
   ccm_csr_if.sink    csr_bus
);
   import ccm_pkg::*;

   // Configuration registers
   logic [RADIUS_W-1:0]       radius_ff;
   logic signed [COORD_W-1:0] center_x_ff;
   logic signed [COORD_W-1:0] center_y_ff;
   logic                      smooth_ff;
   logic [R2_W-1:0]           r2_ff,  r2_in;
   logic [RB2_W-1:0]          rb2_ff, rb2_in;
   logic [DVS_W-1:0]          dvs;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= RADIUS_RST;
         center_x_ff <= '0;
         center_y_ff <= '0;
         smooth_ff   <= 1'b0;
      end else if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_RADIUS:   radius_ff   <= csr_bus.data[RADIUS_W-1:0];
            CSR_CENTER_X: center_x_ff <= csr_bus.data;
            CSR_CENTER_Y: center_y_ff <= csr_bus.data;
            CSR_SMOOTH:   smooth_ff   <= csr_bus.data[0];
            default: ;
         endcase
      end
   end

   // Radius squares follow the radius in the next cycle. The user must write
   // only while the pipeline is empty (unchecked), so stage 4 sees them settled.
   always_comb begin
      r2_in  = R2_W'(radius_ff) * R2_W'(radius_ff);
      rb2_in = (RB2_W'(radius_ff) + RB2_W'(1)) * (RB2_W'(radius_ff) + RB2_W'(1));
   end

   always_ff @(posedge clock) begin
      r2_ff  <= r2_in;
      rb2_ff <= rb2_in;
   end

   // Divisor 2r+1
   assign dvs = {radius_ff, 1'b1};

   // Per-stage valid bits and advance enables
   logic [7:0] vld_ff;
   logic [7:0] adv;

   always_comb begin
      adv[7] = !vld_ff[7] || rsp_bus.ready;
      for (int k = 6; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_bus.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_bus.valid;
         for (int k = 1; k < 8; k++) begin
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Stage 1: offsets from the center
   logic signed [OFFS_W-1:0] s1_dx_ff, s1_dx_in;
   logic signed [OFFS_W-1:0] s1_dy_ff, s1_dy_in;

   always_comb begin
      s1_dx_in = OFFS_W'(req_bus.pixel_x) - OFFS_W'(center_x_ff);
      s1_dy_in = OFFS_W'(req_bus.pixel_y) - OFFS_W'(center_y_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_dx_ff <= s1_dx_in;
         s1_dy_ff <= s1_dy_in;
      end
   end

   // Stage 2: squares
   logic [SQ_W-1:0]        s2_sqx_ff, s2_sqx_in;
   logic [SQ_W-1:0]        s2_sqy_ff, s2_sqy_in;
   logic signed [2*OFFS_W-1:0] prod_x;
   logic signed [2*OFFS_W-1:0] prod_y;

   always_comb begin
      prod_x    = s1_dx_ff * s1_dx_ff;
      prod_y    = s1_dy_ff * s1_dy_ff;
      s2_sqx_in = prod_x[SQ_W-1:0];
      s2_sqy_in = prod_y[SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_sqx_ff <= s2_sqx_in;
         s2_sqy_ff <= s2_sqy_in;
      end
   end

   // Stage 3: squared distance
   logic [D2_W-1:0] s3_d2_ff, s3_d2_in;

   assign s3_d2_in = D2_W'(s2_sqx_ff) + D2_W'(s2_sqy_ff);

   always_ff @(posedge clock) begin
      if (adv[2]) s3_d2_ff <= s3_d2_in;
   end

   // Stage 4: classify against r^2 and (r+1)^2, take the ring remainder
   pix_class_type    s4_cls_ff, s4_cls_in;
   logic [DVS_W-1:0] s4_rem_ff, s4_rem_in;
   logic [D2_W-1:0]  ring_diff;

   always_comb begin
      ring_diff = s3_d2_ff - D2_W'(r2_ff);
      s4_rem_in = ring_diff[DVS_W-1:0];
      if (s3_d2_ff >= D2_W'(rb2_ff)) begin
         s4_cls_in = CLS_OUTSIDE;
      end else if (s3_d2_ff <= D2_W'(r2_ff)) begin
         s4_cls_in = CLS_INSIDE;
      end else begin
         s4_cls_in = CLS_RING;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_cls_ff <= s4_cls_in;
         s4_rem_ff <= s4_rem_in;
      end
   end

   // Stages 5 to 7: two quotient bits each
   div_step_type     s5_a, s5_b, s6_a, s6_b, s7_a, s7_b, s8_a, s8_b;
   pix_class_type    s5_cls_ff, s6_cls_ff, s7_cls_ff;
   logic [DVS_W-1:0] s5_rem_ff, s6_rem_ff, s7_rem_ff;
   logic [1:0]       s5_q_ff, s5_q_in;
   logic [3:0]       s6_q_ff, s6_q_in;
   logic [5:0]       s7_q_ff, s7_q_in;

   always_comb begin
      s5_a    = div_step(s4_rem_ff, dvs);
      s5_b    = div_step(s5_a.rem, dvs);
      s5_q_in = {s5_a.qbit, s5_b.qbit};
      s6_a    = div_step(s5_rem_ff, dvs);
      s6_b    = div_step(s6_a.rem, dvs);
      s6_q_in = {s5_q_ff, s6_a.qbit, s6_b.qbit};
      s7_a    = div_step(s6_rem_ff, dvs);
      s7_b    = div_step(s7_a.rem, dvs);
      s7_q_in = {s6_q_ff, s7_a.qbit, s7_b.qbit};
      s8_a    = div_step(s7_rem_ff, dvs);
      s8_b    = div_step(s8_a.rem, dvs);
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_cls_ff <= s4_cls_ff;
         s5_rem_ff <= s5_b.rem;
         s5_q_ff   <= s5_q_in;
      end
      if (adv[5]) begin
         s6_cls_ff <= s5_cls_ff;
         s6_rem_ff <= s6_b.rem;
         s6_q_ff   <= s6_q_in;
      end
      if (adv[6]) begin
         s7_cls_ff <= s6_cls_ff;
         s7_rem_ff <= s7_b.rem;
         s7_q_ff   <= s7_q_in;
      end
   end

   // Stage 8: last two quotient bits, alpha into the output register.
   // On the ring, 255 - q is just the complement of q.
   logic [ALPHA_W-1:0] s8_alpha_ff, s8_alpha_in;
   logic [ALPHA_W-1:0] quot;

   always_comb begin
      quot = {s7_q_ff, s8_a.qbit, s8_b.qbit};
      case (s7_cls_ff)
         CLS_INSIDE: s8_alpha_in = ALPHA_FULL;
         CLS_RING:   s8_alpha_in = smooth_ff ? ~quot : ALPHA_NONE;
         default:    s8_alpha_in = ALPHA_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[7]) s8_alpha_ff <= s8_alpha_in;
   end

   assign rsp_bus.valid = vld_ff[7];
   assign rsp_bus.alpha = s8_alpha_ff;

endmodule
`default_nettype wire
